// ===== design/compass_heading_from_field_defines.svh =====
// assertion macros for the checker file of the compass heading block
`ifndef COMPASS_HEADING_FROM_FIELD_DEFINES_SVH
`define COMPASS_HEADING_FROM_FIELD_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CHFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CHFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/chfc_pkg.sv =====
// shared types, constants and tables of the compass heading pipeline
`timescale 1ns / 1ps

package chfc_pkg;

	// cordic depth and arctangent table length
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int CORDIC_RUN    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int SHIFT_W       = 5;

	// field widths
	localparam int FIELD_W = 16;
	localparam int DECL_W  = 16;
	localparam int DIR_W   = 17;
	localparam int HEAD_W  = 16;
	localparam int IN_W    = 32;
	localparam int OUT_W   = 40;

	// datapath widths: scaled vector and q20 angle
	localparam int PRE_SHIFT = 14;
	localparam int XY_W      = 33;
	localparam int Z_W       = 24;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-1:0] DECL_ADDR = 3'd0;

	// angle and conversion constants
	localparam logic signed [Z_W-1:0] PI_Q20 = 24'sd3294199;
	localparam int PROD_W = 40;
	localparam logic signed [PROD_W-1:0] RAD2DEG_Q16 = 40'sd3754936;
	localparam logic signed [PROD_W:0] DEG_ROUND = 41'sd4194304;
	localparam logic signed [17:0] FULL_TURN_Q6 = 18'sd23040;

	// vector and angle carried through the cordic stages
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
	} cordic_t;

	// atan(2^-i) in q20 radians
	function automatic logic signed [Z_W-1:0] atan_q20(input int idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			0:       v = 24'sd823550;
			1:       v = 24'sd486170;
			2:       v = 24'sd256879;
			3:       v = 24'sd130396;
			4:       v = 24'sd65451;
			5:       v = 24'sd32757;
			6:       v = 24'sd16383;
			7:       v = 24'sd8192;
			8:       v = 24'sd4096;
			9:       v = 24'sd2048;
			10:      v = 24'sd1024;
			11:      v = 24'sd512;
			12:      v = 24'sd256;
			13:      v = 24'sd128;
			14:      v = 24'sd64;
			15:      v = 24'sd32;
			16:      v = 24'sd16;
			17:      v = 24'sd8;
			18:      v = 24'sd4;
			19:      v = 24'sd2;
			20:      v = 24'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/chfc_stage.sv =====
// one registered vectoring cordic iteration
`timescale 1ns / 1ps

module chfc_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [chfc_pkg::SHIFT_W-1:0]   shift,
	input  logic signed [chfc_pkg::Z_W-1:0] atan_step,
	input  logic                           valid_in,
	input  chfc_pkg::cordic_t              vec_in,
	output logic                           valid_out,
	output chfc_pkg::cordic_t              vec_out
);
	import chfc_pkg::*;

	logic signed [XY_W-1:0] x_c;
	logic signed [XY_W-1:0] y_c;
	logic signed [XY_W-1:0] xs_c;
	logic signed [XY_W-1:0] ys_c;
	cordic_t                nxt_c;

	// rotate toward the x axis, direction from the sign of y
	always_comb begin
		x_c  = vec_in.x;
		y_c  = vec_in.y;
		xs_c = x_c >>> shift;
		ys_c = y_c >>> shift;
		nxt_c.zero = vec_in.zero;
		if (!y_c[XY_W-1]) begin
			nxt_c.x = x_c + ys_c;
			nxt_c.y = y_c - xs_c;
			nxt_c.z = vec_in.z + atan_step;
		end else begin
			nxt_c.x = x_c - ys_c;
			nxt_c.y = y_c + xs_c;
			nxt_c.z = vec_in.z - atan_step;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			vec_out <= nxt_c;
		end
	end

endmodule

// ===== design/chfc_post.sv =====
// angle to direction and heading: round, add declination, scale to degrees, wrap, saturate
`timescale 1ns / 1ps

module chfc_post (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic signed [chfc_pkg::DECL_W-1:0]  decl,
	input  logic                                valid_in,
	input  chfc_pkg::cordic_t                   vec_in,
	output logic                                valid_out,
	output logic signed [chfc_pkg::DIR_W-1:0]   direction,
	output logic signed [chfc_pkg::HEAD_W-1:0]  heading
);
	import chfc_pkg::*;

	logic signed [Z_W-1:0]    ang_c;
	logic signed [Z_W:0]      ang_rnd_c;
	logic signed [Z_W-7:0]    ang_q13_c;
	logic signed [Z_W-6:0]    dir_sum_c;
	logic signed [DIR_W-1:0]  dir_c;
	logic signed [DIR_W-1:0]  dir_s1;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PROD_W:0]   deg_sum_c;
	logic signed [17:0]       deg_c;
	logic signed [17:0]       deg_wrap_c;
	logic signed [HEAD_W-1:0] head_c;
	logic                     v_s1;
	logic                     v_s2;

	// q20 to q13 with rounding, plus declination, saturated
	always_comb begin
		ang_c     = vec_in.zero ? '0 : vec_in.z;
		ang_rnd_c = (Z_W+1)'(ang_c) + (Z_W+1)'(64);
		ang_q13_c = ang_rnd_c[Z_W:7];
		dir_sum_c = (Z_W-5)'(ang_q13_c) + (Z_W-5)'(decl);
		if (dir_sum_c < -(Z_W-5)'(65536)) begin
			dir_c = -(DIR_W)'(65536);
		end else if (dir_sum_c > (Z_W-5)'(65535)) begin
			dir_c = (DIR_W)'(65535);
		end else begin
			dir_c = dir_sum_c[DIR_W-1:0];
		end
	end

	// radians to degrees, q13 times q16
	assign prod_c = PROD_W'(dir_s1) * RAD2DEG_Q16;

	// round to q6, wrap negatives by a full turn, saturate
	always_comb begin
		deg_sum_c = (PROD_W+1)'(prod_s2) + DEG_ROUND;
		deg_c     = deg_sum_c[PROD_W:23];
		deg_wrap_c = deg_c[17] ? (deg_c + FULL_TURN_Q6) : deg_c;
		if (deg_wrap_c < -18'sd32768) begin
			head_c = -(HEAD_W)'(32768);
		end else if (deg_wrap_c > 18'sd32767) begin
			head_c = (HEAD_W)'(32767);
		end else begin
			head_c = deg_wrap_c[HEAD_W-1:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			valid_out <= 1'b0;
		end else if (en) begin
			v_s1      <= valid_in;
			v_s2      <= v_s1;
			valid_out <= v_s2;
		end
	end

	// payload registers
	logic signed [DIR_W-1:0] dir_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			dir_s1    <= dir_c;
			prod_s2   <= prod_c;
			dir_s2    <= dir_s1;
			direction <= dir_s2;
			heading   <= head_c;
		end
	end

endmodule

// ===== design/compass_heading_from_field.sv =====
// compass heading top level: config register, input stage, cordic chain, output
//
// channel   | dir | fields (low bit first)
// s_axis    | in  | tdata: field_x[15:0], field_y[31:16]
// m_axis    | out | tdata: direction_rad[16:0], heading_deg[32:17], zero pad to 40
// apb       | in  | declination at byte address 0
//
// one sample per cycle while the output beat is not held; pipeline: one input stage, one stage per
// cordic iteration (16), three output stages (round and declination,
// degree multiply, wrap and saturate)
// arst_n clears the valid bits and the declination to zero
// a held output beat stalls every stage at once, so nothing is lost or repeated
`timescale 1ns / 1ps

module compass_heading_from_field (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [chfc_pkg::IN_W-1:0]         s_axis_tdata,  // field_x, field_y
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [chfc_pkg::OUT_W-1:0]        m_axis_tdata,  // direction_rad, heading_deg, pad
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [chfc_pkg::ADDR_W-1:0]       paddr,
	input  logic [chfc_pkg::DATA_W-1:0]       pwdata,
	output logic [chfc_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);
	import chfc_pkg::*;

	logic signed [DECL_W-1:0]  decl_q;
	logic                      en;
	logic signed [FIELD_W-1:0] fx_c;
	logic signed [FIELD_W-1:0] fy_c;
	logic signed [FIELD_W:0]   xa_c;
	logic signed [FIELD_W:0]   ya_c;
	cordic_t                   pre_c;
	logic                      vld [CORDIC_RUN+1];
	cordic_t                   vec [CORDIC_RUN+1];
	logic signed [DIR_W-1:0]   dir;
	logic signed [HEAD_W-1:0]  head;

	// declination register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= '0;
		end else if (psel && penable && pwrite && (paddr == DECL_ADDR)) begin
			decl_q <= pwdata[DECL_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == DECL_ADDR) ? DATA_W'(decl_q) : '0;

	// whole pipe moves unless the output beat is held
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// fold left half plane over, preset angle to +-pi, scale up
	always_comb begin
		fx_c = s_axis_tdata[FIELD_W-1:0];
		fy_c = s_axis_tdata[2*FIELD_W-1:FIELD_W];
		if (fx_c[FIELD_W-1]) begin
			xa_c    = -(FIELD_W+1)'(fx_c);
			ya_c    = -(FIELD_W+1)'(fy_c);
			pre_c.z = fy_c[FIELD_W-1] ? -PI_Q20 : PI_Q20;
		end else begin
			xa_c    = (FIELD_W+1)'(fx_c);
			ya_c    = (FIELD_W+1)'(fy_c);
			pre_c.z = '0;
		end
		pre_c.x    = XY_W'(xa_c) <<< PRE_SHIFT;
		pre_c.y    = XY_W'(ya_c) <<< PRE_SHIFT;
		pre_c.zero = (fx_c == '0) && (fy_c == '0);
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec[0] <= pre_c;
		end
	end

	// cordic iterations, one register stage each
	for (genvar k = 0; k < CORDIC_RUN; k++) begin : g_stage
		chfc_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.shift     (SHIFT_W'(k)),
			.atan_step (atan_q20(k)),
			.valid_in  (vld[k]),
			.vec_in    (vec[k]),
			.valid_out (vld[k+1]),
			.vec_out   (vec[k+1])
		);
	end

	// output conversion and result register
	chfc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.decl      (decl_q),
		.valid_in  (vld[CORDIC_RUN]),
		.vec_in    (vec[CORDIC_RUN]),
		.valid_out (m_axis_tvalid),
		.direction (dir),
		.heading   (head)
	);

	assign m_axis_tdata = {(OUT_W-DIR_W-HEAD_W)'(0), head, dir};

endmodule

// ===== design/chfc_checker.sv =====
// port-level checker for the compass heading block, bound to the top level
`timescale 1ns / 1ps
`include "compass_heading_from_field_defines.svh"

module chfc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [chfc_pkg::OUT_W-1:0]  m_axis_tdata,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [chfc_pkg::ADDR_W-1:0] paddr,
	input logic [chfc_pkg::DATA_W-1:0] pwdata,
	input logic [chfc_pkg::DATA_W-1:0] prdata,
	input logic                        pready
);
	import chfc_pkg::*;

	// a held result beat keeps its value
	`CHFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

	// with no result waiting the block always takes a beat
	`CHFC_ASSERT_NOW(a_ready_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

	// a written declination reads back
	`CHFC_ASSERT_NEXT(a_readback, psel && penable && pwrite && pready && (paddr == DECL_ADDR), (paddr != DECL_ADDR) || (prdata[DECL_W-1:0] == $past(pwdata[DECL_W-1:0])), "declination readback mismatch")

	// pad bits above the heading stay zero
	`CHFC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_W-1:DIR_W+HEAD_W] == '0, "result pad bits set")

endmodule

bind compass_heading_from_field chfc_checker u_chfc_checker (.*);

// ===== verif/compass_heading_from_field_tb.sv =====
// self-checking testbench of the compass heading block: cordic atan2 and degree wrap
`timescale 1ns / 1ps

module compass_heading_from_field_tb;

	import chfc_pkg::*;

	localparam int PIPE_LATENCY = 20;
	localparam int LONG_HOLD    = 200;
	localparam int PHASE_BEATS  = 56;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int MAX_REPORTS  = 10;
	localparam int TIMEOUT_NS   = 8000000;
	localparam int PLAN_LEN     = 21;

	// byte address of the first register past the map; writes there are dropped
	localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;

	// fixed-point constants of the heading math
	localparam longint ANGLE_PI     = 64'sd3294199;
	localparam longint RAD_TO_DEG   = 64'sd3754936;
	localparam longint TURN_DEG_Q6  = 64'sd23040;
	localparam longint DIR_MIN      = -64'sd65536;
	localparam longint DIR_MAX      = 64'sd65535;
	localparam longint HEAD_MIN     = -64'sd32768;
	localparam longint HEAD_MAX     = 64'sd32767;

	// atan(2^-i) in q20 radians
	localparam longint ARC_Q20 [24] = '{
		823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2, 1, 0, 0, 0
	};

	// expected output beat, with the sample that caused it
	typedef struct packed {
		logic signed [FIELD_W-1:0] fx;
		logic signed [FIELD_W-1:0] fy;
		logic signed [DIR_W-1:0]   dir;
		logic signed [HEAD_W-1:0]  head;
	} bearing_t;

	// directed sample; known rows carry the result typed in
	typedef struct packed {
		int fx;
		int fy;
		bit known;
		int dir;
		int head;
	} plan_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata;   // field_x[15:0], field_y[31:16]
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_W-1:0]    m_axis_tdata;   // direction_rad[16:0], heading_deg[32:17], pad
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	bearing_t                 pending_bearings [$];
	logic signed [DECL_W-1:0] decl_shadow;
	int                       fail_count;
	int                       burst_left;
	bit                       stall_request;
	plan_row_t                sample_plan [PLAN_LEN];

	compass_heading_from_field u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// heading of one field sample under the given declination
	function automatic bearing_t predict_bearing(input logic signed [FIELD_W-1:0] fx,
		input logic signed [FIELD_W-1:0] fy, input logic signed [DECL_W-1:0] decl);
		longint   vx;
		longint   vy;
		longint   ang;
		longint   sx;
		longint   sy;
		longint   dir;
		longint   deg;
		int       i;
		bearing_t r;
		vx  = fx;
		vy  = fy;
		ang = 0;
		if (!(vx == 0 && vy == 0)) begin
			// fold the left half plane onto the right one
			if (vx < 0) begin
				ang = (vy >= 0) ? ANGLE_PI : -ANGLE_PI;
				vx  = -vx;
				vy  = -vy;
			end
			vx = vx * 16384;
			vy = vy * 16384;
			for (i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
				sx = vx >>> i;
				sy = vy >>> i;
				if (vy >= 0) begin
					vx  = vx + sy;
					vy  = vy - sx;
					ang = ang + ARC_Q20[i];
				end else begin
					vx  = vx - sy;
					vy  = vy + sx;
					ang = ang - ARC_Q20[i];
				end
			end
		end
		// q20 to q13 with rounding, then declination and saturation
		dir = ((ang + 64) >>> 7) + longint'(decl);
		dir = (dir < DIR_MIN) ? DIR_MIN : ((dir > DIR_MAX) ? DIR_MAX : dir);
		// radians to degrees in q6, wrapped into the positive turn
		deg = (dir * RAD_TO_DEG + (64'sd1 <<< 22)) >>> 23;
		if (deg < 0)
			deg = deg + TURN_DEG_Q6;
		deg = (deg < HEAD_MIN) ? HEAD_MIN : ((deg > HEAD_MAX) ? HEAD_MAX : deg);
		r.fx   = fx;
		r.fy   = fy;
		r.dir  = dir[DIR_W-1:0];
		r.head = deg[HEAD_W-1:0];
		return r;
	endfunction

	function automatic void report_issue(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, what);
	endfunction

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin
		bearing_t want;
		logic signed [DIR_W-1:0]  got_dir;
		logic signed [HEAD_W-1:0] got_head;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_dir  = m_axis_tdata[DIR_W-1:0];
			got_head = m_axis_tdata[DIR_W+HEAD_W-1:DIR_W];
			if (pending_bearings.size() == 0) begin
				report_issue($sformatf("unexpected beat dir=%0d head=%0d", got_dir, got_head));
			end else begin
				want = pending_bearings.pop_front();
				if (got_dir !== want.dir || got_head !== want.head)
					report_issue($sformatf("x=%0d y=%0d: dir exp %0d got %0d, head exp %0d got %0d",
						want.fx, want.fy, want.dir, got_dir, want.head, got_head));
			end
		end
	end

	// receiver: stall patterns of random span, plus a long hold on request
	initial begin
		int mode;
		int span_left;
		int tick;
		m_axis_tready = 1'b0;
		span_left     = 0;
		tick          = 0;
		mode          = 0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (span_left == 0) begin
					mode      = $urandom_range(0, 3);
					span_left = $urandom_range(8, 80);
				end
				span_left--;
				tick++;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (tick % 4 == 0);
					default: m_axis_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// apb access: setup then access phase, then an idle phase; a read checks the declination
	task automatic apb_access(input bit is_write, input logic [ADDR_W-1:0] addr,
		input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (is_write && addr == DECL_ADDR)
			decl_shadow = data[DECL_W-1:0];
		if (!is_write && prdata[DECL_W-1:0] !== decl_shadow)
			report_issue($sformatf("declination read exp %0d got %0d", decl_shadow,
				$signed(prdata[DECL_W-1:0])));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// hold the sender until every result is back and the pipe is empty
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_bearings.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	// bursts of random length with random gaps between them
	task automatic sender_pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	// offer one sample and log its expected result once accepted
	task automatic send_sample(input logic signed [FIELD_W-1:0] fx,
		input logic signed [FIELD_W-1:0] fy, input bit known,
		input logic signed [DIR_W-1:0] dir, input logic signed [HEAD_W-1:0] head);
		bearing_t want;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {fy, fx};
		do @(posedge clk); while (!s_axis_tready);
		if (known) begin
			want.fx   = fx;
			want.fy   = fy;
			want.dir  = dir;
			want.head = head;
		end else begin
			want = predict_bearing(fx, fy, decl_shadow);
		end
		pending_bearings.push_back(want);
		@(negedge clk);
	endtask

	function automatic logic signed [FIELD_W-1:0] rail_value();
		case ($urandom_range(0, 5))
			0: return -16'sd32767 - 16'sd1;
			1: return -16'sd32767;
			2: return -16'sd1;
			3: return 16'sd0;
			4: return 16'sd1;
			default: return 16'sd32767;
		endcase
	endfunction

	// random sample: full range, small, axis, rail and diagonal cases, full range the most common
	task automatic pick_fields(output logic signed [FIELD_W-1:0] fx,
		output logic signed [FIELD_W-1:0] fy);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				fx = FIELD_W'($urandom);
				fy = FIELD_W'($urandom);
			end
			4, 5: begin
				fx = 16'(int'($urandom_range(0, 16)) - 8);
				fy = 16'(int'($urandom_range(0, 16)) - 8);
			end
			6: begin
				fx = FIELD_W'($urandom);
				fy = FIELD_W'($urandom);
				if ($urandom_range(0, 1))
					fx = 16'sd0;
				else
					fy = 16'sd0;
			end
			7, 8: begin
				fx = rail_value();
				fy = rail_value();
			end
			default: begin
				fx = FIELD_W'($urandom);
				fy = $urandom_range(0, 1) ? fx : -fx;
			end
		endcase
	endtask

	initial begin
		int                       p;
		int                       k;
		int                       drain_wait;
		logic signed [FIELD_W-1:0] fx;
		logic signed [FIELD_W-1:0] fy;
		logic signed [DECL_W-1:0]  decl_plan [7];

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		decl_shadow   = '0;
		fail_count    = 0;
		burst_left    = 0;
		stall_request = 1'b0;

		// axes, rails, diagonals and unit vectors; zero vector typed in
		sample_plan = '{
			'{0, 0, 1'b1, 0, 0},
			'{32767, 0, 1'b0, 0, 0},
			'{-32768, 0, 1'b0, 0, 0},
			'{-1, 0, 1'b0, 0, 0},
			'{0, 32767, 1'b0, 0, 0},
			'{0, -32768, 1'b0, 0, 0},
			'{32767, 32767, 1'b0, 0, 0},
			'{-32768, -32768, 1'b0, 0, 0},
			'{-32768, 32767, 1'b0, 0, 0},
			'{32767, -32768, 1'b0, 0, 0},
			'{1, 0, 1'b0, 0, 0},
			'{0, 1, 1'b0, 0, 0},
			'{0, -1, 1'b0, 0, 0},
			'{-1, -1, 1'b0, 0, 0},
			'{-1, 1, 1'b0, 0, 0},
			'{1, -1, 1'b0, 0, 0},
			'{1, 1, 1'b0, 0, 0},
			'{-32768, -1, 1'b0, 0, 0},
			'{-32768, 1, 1'b0, 0, 0},
			'{21845, -21846, 1'b0, 0, 0},
			'{-21846, 21845, 1'b0, 0, 0}
		};

		decl_plan[0] = 16'sd32767;
		decl_plan[1] = -16'sd32767 - 16'sd1;
		decl_plan[2] = -16'sd1;
		decl_plan[3] = 16'sd1;
		decl_plan[4] = DECL_W'($urandom);
		decl_plan[5] = DECL_W'($urandom);
		decl_plan[6] = 16'sd0;

		// reset held, then released on a falling clock edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// declination comes out of reset at zero
		apb_access(1'b0, DECL_ADDR, '0);

		// directed samples under zero declination
		for (p = 0; p < PLAN_LEN; p++)
			send_sample(16'(sample_plan[p].fx), 16'(sample_plan[p].fy), sample_plan[p].known,
				17'(sample_plan[p].dir), 16'(sample_plan[p].head));

		// random phases, one declination each, written while the pipe is empty
		for (p = 0; p < 7; p++) begin
			wait_drained();
			apb_access(1'b1, DECL_ADDR, {{(DATA_W-DECL_W){decl_plan[p][DECL_W-1]}}, decl_plan[p]});
			apb_access(1'b1, SPARE_ADDR, $urandom);
			apb_access(1'b0, DECL_ADDR, '0);
			if (p == 1)
				stall_request = 1'b1;
			for (k = 0; k < PHASE_BEATS; k++) begin
				// sender stops midway once and lets the results catch up
				if (p == 3 && k == PHASE_BEATS / 2)
					wait_drained();
				sender_pace();
				pick_fields(fx, fy);
				send_sample(fx, fy, 1'b0, '0, '0);
			end
		end

		// drain and settle
		s_axis_tvalid <= 1'b0;
		drain_wait = 0;
		while (pending_bearings.size() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (pending_bearings.size() != 0)
			report_issue($sformatf("%0d expected results never arrived",
				pending_bearings.size()));
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule
